// ===== rtl/lcip_pkg.sv =====
`timescale 1ns / 1ps

package lcip_pkg;

    localparam int PIX_W     = 8;
    localparam int COEF_W    = 16;
    localparam int RES_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int ROM_DEPTH = 256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS = 2'd0,
        CFG_SIN = 2'd1
    } t_cfg_idx;

    localparam logic signed [COEF_W-1:0] COS_RESET = 16'sd16384;
    localparam logic signed [COEF_W-1:0] SIN_RESET = 16'sd0;

    // ln(2) * 2^64, rounded
    localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;
    localparam int LOG2_FRAC = 48;

    // round(ln(v) * 2^frac), evaluated at elaboration only; v = 0 reads as ln(1)
    function automatic logic [31:0] ln_entry(input int unsigned v, input int unsigned frac);
        logic [63:0]  x;
        logic [63:0]  res;
        logic [63:0]  hi;
        logic [127:0] p;
        int unsigned  n;
        n = 0;
        if (v == 0) begin
            return 32'd0;
        end
        for (int k = 1; k < 32; k++) begin
            if ((v >> k) != 0) n = k;
        end
        x   = 64'(v) << (63 - n);
        res = 64'(n) << LOG2_FRAC;
        for (int i = LOG2_FRAC - 1; i >= 0; i--) begin
            p = {64'd0, x} * {64'd0, x};
            if (p[127]) begin
                x      = p[127:64];
                res[i] = 1'b1;
            end else begin
                x = p[126:63];
            end
        end
        p  = {64'd0, res} * {64'd0, LN2_Q64};
        hi = p[127:64];
        return 32'((hi + (64'd1 << (LOG2_FRAC - 1 - frac))) >> (LOG2_FRAC - frac));
    endfunction

endpackage

// ===== rtl/log_chroma_invariant_projection_unit.sv =====
`timescale 1ns / 1ps

// Log-chromaticity illumination-invariant projection.
// Input stream (i_s_*): one RGB pixel per item, tdata = {blue, green, red}.
// Output stream (o_m_*): one signed Q3.12 invariant per item, in input order.
// Config port: i_cfg_we with i_cfg_idx 0 writes cos_coef, 1 writes sin_coef
// (signed Q1.14); other indexes are ignored. Write only while the pipe is empty.
// Function: invariant = sat16(((ln r - ln g)*cos + (ln b - ln g)*sin) >>> 14),
// logs from a 256-entry ln ROM built at elaboration, zero channel reads as ln 1.
// Pipeline: five register stages from input accept to o_m_tvalid
// (input, ROM read, log differences, products, sum/shift/saturate).
// Throughput: one item per clock unless stalled; each stage hands on when the
// next is empty or moving, so bubbles are squeezed out; a stall loses nothing.
// Stall: while i_m_tready is low the pipe fills up; o_s_tready drops only
// once every stage holds an item.
// Reset (i_rst_n low, synchronous): pipe emptied, cos = 1.0, sin = 0.
module log_chroma_invariant_projection_unit #(
    parameter int LOG_FRAC_BITS  = 12,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] invariant
    // config write port
    input  logic        i_cfg_we,
    input  logic [lcip_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lcip_pkg::COEF_W-1:0]    i_cfg_data
);

    // ln(255) < 5.55, so three integer bits
    localparam int LOG_W = LOG_FRAC_BITS + 3;
    localparam int PW    = lcip_pkg::PIX_W;

    // constant log table
    logic [LOG_W-1:0] w_rom [lcip_pkg::ROM_DEPTH];

    for (genvar v = 0; v < lcip_pkg::ROM_DEPTH; v++) begin : g_rom
        localparam logic [31:0] ENTRY = lcip_pkg::ln_entry(v, LOG_FRAC_BITS);
        assign w_rom[v] = ENTRY[LOG_W-1:0];
    end

    // config registers
    logic signed [lcip_pkg::COEF_W-1:0] r_cos;
    logic signed [lcip_pkg::COEF_W-1:0] r_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos <= lcip_pkg::COS_RESET;
            r_sin <= lcip_pkg::SIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lcip_pkg::CFG_COS: r_cos <= i_cfg_data;
                lcip_pkg::CFG_SIN: r_sin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline state
    logic                r_vld1, r_vld2, r_vld3;
    logic [PW-1:0]       r_red, r_grn, r_blu;
    logic [LOG_W-1:0]    r_lr, r_lg, r_lb;
    logic signed [LOG_W:0] r_dx, r_dy;
    logic                w_en1, w_en2, w_en3;
    logic                w_proj_rdy;
    logic signed [lcip_pkg::RES_W-1:0] w_res;

    // a stage loads when it is empty or its content moves on
    assign w_en3 = !r_vld3 || w_proj_rdy;
    assign w_en2 = !r_vld2 || w_en3;
    assign w_en1 = !r_vld1 || w_en2;
    assign o_s_tready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (w_en1) r_vld1 <= i_s_tvalid;
            if (w_en2) r_vld2 <= r_vld1;
            if (w_en3) r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_red <= i_s_tdata[PW-1:0];
            r_grn <= i_s_tdata[2*PW-1:PW];
            r_blu <= i_s_tdata[3*PW-1:2*PW];
        end
        // ROM read; entry 0 holds 0, so a zero channel acts as 1
        if (w_en2) begin
            r_lr <= w_rom[r_red];
            r_lg <= w_rom[r_grn];
            r_lb <= w_rom[r_blu];
        end
        if (w_en3) begin
            r_dx <= $signed({1'b0, r_lr}) - $signed({1'b0, r_lg});
            r_dy <= $signed({1'b0, r_lb}) - $signed({1'b0, r_lg});
        end
    end

    lcip_proj #(
        .LOG_W          (LOG_W),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld3),
        .o_rdy   (w_proj_rdy),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .i_cos   (r_cos),
        .i_sin   (r_sin),
        .o_vld   (o_m_tvalid),
        .i_rdy   (i_m_tready),
        .o_res   (w_res)
    );

    assign o_m_tdata = w_res;

`ifndef ASSERT_OFF
    // an empty first stage never refuses an item
    a_rdy_when_empty: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) !r_vld1 |-> o_s_tready)
        else $error("input stalled with empty first stage");

    // an accepted item lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) (i_s_tvalid && o_s_tready) |=> r_vld1)
        else $error("accepted item lost at first stage");

    // reset leaves no result behind
    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

// ===== rtl/lcip_proj.sv =====
`timescale 1ns / 1ps

// Projection stages: products, then sum / floor shift / saturate.
module lcip_proj #(
    parameter int LOG_W          = 15,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    output logic                                o_rdy,
    input  logic signed [LOG_W:0]               i_dx,
    input  logic signed [LOG_W:0]               i_dy,
    input  logic signed [lcip_pkg::COEF_W-1:0]  i_cos,
    input  logic signed [lcip_pkg::COEF_W-1:0]  i_sin,
    output logic                                o_vld,
    input  logic                                i_rdy,
    output logic signed [lcip_pkg::RES_W-1:0]   o_res
);

    localparam int PW = LOG_W + 1 + lcip_pkg::COEF_W;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] MAX_V = SW'((1 << (lcip_pkg::RES_W - 1)) - 1);
    localparam logic signed [SW-1:0] MIN_V = -SW'(1 << (lcip_pkg::RES_W - 1));

    logic                  r_vld4;
    logic                  r_vld5;
    logic signed [PW-1:0]  r_px;
    logic signed [PW-1:0]  r_py;
    logic signed [lcip_pkg::RES_W-1:0] r_res;
    logic                  w_en4;
    logic                  w_en5;
    logic signed [SW-1:0]  w_sum;
    logic signed [SW-1:0]  w_sh;
    logic signed [lcip_pkg::RES_W-1:0] n_res;

    assign w_en5 = !r_vld5 || i_rdy;
    assign w_en4 = !r_vld4 || w_en5;
    assign o_rdy = w_en4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            if (w_en4) r_vld4 <= i_vld;
            if (w_en5) r_vld5 <= r_vld4;
        end
    end

    always_comb begin
        w_sum = SW'(r_px) + SW'(r_py);
        w_sh  = w_sum >>> COEF_FRAC_BITS;
        if (w_sh > MAX_V) begin
            n_res = MAX_V[lcip_pkg::RES_W-1:0];
        end else if (w_sh < MIN_V) begin
            n_res = MIN_V[lcip_pkg::RES_W-1:0];
        end else begin
            n_res = w_sh[lcip_pkg::RES_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_px <= PW'(i_dx) * PW'(i_cos);
            r_py <= PW'(i_dy) * PW'(i_sin);
        end
        if (w_en5) r_res <= n_res;
    end

    assign o_vld = r_vld5;
    assign o_res = r_res;

endmodule
